[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker of the FM bell tone block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define FBT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that is also checked during reset.
`define FBT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/fbt_pkg.sv]
// ----------------------------------------------------------------------------
// fbt_pkg
// Types, constants and the sine table builder of the FM bell tone block.
// ----------------------------------------------------------------------------
package fbt_pkg;

   // Default values of the top level parameters.
   localparam int unsigned INDEX_BITS_DEFAULT      = 20;
   localparam int unsigned SINE_TABLE_BITS_DEFAULT = 10;

   // Register and sample widths.
   localparam int unsigned STEP_W   = 32;
   localparam int unsigned DEPTH_W  = 16;
   localparam int unsigned AMP_W    = 15;
   localparam int unsigned SAMPLE_W = 16;

   // Register reset values.
   localparam logic [STEP_W-1:0]  CARRIER_STEP_RESET   = 32'd19478310;
   localparam logic [STEP_W-1:0]  MODULATOR_STEP_RESET = 32'd27269633;
   localparam logic [DEPTH_W-1:0] MOD_DEPTH_RESET      = 16'd2608;
   localparam logic [AMP_W-1:0]   AMPLITUDE_RESET      = 15'd32767;
   localparam logic [STEP_W-1:0]  DECAY_COEF_RESET     = 32'd68849;

   // Envelope constants: ln(2) in Q0.32 and one in Q30.
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [30:0] Q30_ONE = 31'd1073741824;

   // Number of terms of the exp() series, one pipeline step each.
   localparam int unsigned EXP_TERMS = 11;

   // Queue between front and back.
   localparam int unsigned QUEUE_DEPTH    = 4;
   localparam int unsigned QUEUE_PTR_BITS = 2;

   // Quarter wave polynomial coefficients, Q30.
   localparam logic [63:0] SC1  = 64'd1686629713;
   localparam logic [63:0] SC3  = 64'd693598668;
   localparam logic [63:0] SC5  = 64'd85569306;
   localparam logic [63:0] SC7  = 64'd5026995;
   localparam logic [63:0] SC9  = 64'd172272;
   localparam logic [63:0] SC11 = 64'd3864;

   // One classified item as it leaves the front.
   typedef struct packed {
      logic [31:0] carrier_phase;
      logic [31:0] mod_phase;
      logic [31:0] decay_frac;
      logic [4:0]  decay_shift;
      logic        silent;
   } qent_type;

   // One item inside the exp() series.
   typedef struct packed {
      logic signed [15:0] sine;
      logic [4:0]         decay_shift;
      logic               silent;
      logic [29:0]        y;
      logic [30:0]        p;
   } hterm_type;

   // Sine table entry k in Q1.15, built from an odd quarter wave polynomial.
   function automatic logic signed [15:0] sine_entry(input int unsigned k,
                                                     input int unsigned tbits);
      int unsigned        qbits;
      int unsigned        quad;
      logic [63:0]        r;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        p;
      logic [63:0]        s;
      logic signed [15:0] v;
      qbits = tbits - 2;
      quad  = (k >> qbits) & 3;
      r     = 64'(k & ((1 << qbits) - 1));
      if ((quad & 1) != 0) begin
         r = (64'd1 << qbits) - r;
      end
      x  = r << (30 - qbits);
      x2 = (x * x) >> 30;
      p  = SC11;
      p  = SC9 - ((p * x2) >> 30);
      p  = SC7 - ((p * x2) >> 30);
      p  = SC5 - ((p * x2) >> 30);
      p  = SC3 - ((p * x2) >> 30);
      p  = SC1 - ((p * x2) >> 30);
      s  = (p * x) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      v = 16'(s);
      return ((quad & 2) != 0) ? -v : v;
   endfunction

endpackage

[rtl/fm_bell_tone_sample.sv]
// ----------------------------------------------------------------------------
// fm_bell_tone_sample
// Two-operator FM bell tone sample generator with exponential decay.
// ----------------------------------------------------------------------------
// The block takes one sample index per clock and returns one signed 16-bit
// sample per index, in order, one result per cycle when neither side stalls.
// An accepted index passes through the front register and the queue, then
// through the 39-stage sample pipeline, most of which is the eleven-term exp()
// series for the decay envelope at three stages per term.
// The queue between the front and the pipeline holds four beats. Registers
// sit on an APB-style port (byte address 4*i); the user must write them only
// while idle, which the block itself does not enforce.
module fm_bell_tone_sample #(
   parameter int unsigned INDEX_BITS      = fbt_pkg::INDEX_BITS_DEFAULT,
   parameter int unsigned SINE_TABLE_BITS = fbt_pkg::SINE_TABLE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [INDEX_BITS-1:0] req_sample_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [fbt_pkg::SAMPLE_W-1:0] rsp_sample_value,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [4:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import fbt_pkg::*;

   typedef enum logic [2:0] {
      REG_CARRIER_STEP   = 3'd0,
      REG_MODULATOR_STEP = 3'd1,
      REG_MOD_DEPTH      = 3'd2,
      REG_AMPLITUDE      = 3'd3,
      REG_DECAY_COEF     = 3'd4
   } reg_index_type;

   logic [STEP_W-1:0]  carrier_step_ff;
   logic [STEP_W-1:0]  modulator_step_ff;
   logic [DEPTH_W-1:0] mod_depth_ff;
   logic [AMP_W-1:0]   amplitude_ff;
   logic [STEP_W-1:0]  decay_coef_ff;
   logic               wr_en;
   reg_index_type      reg_sel;

   logic     q_full;
   logic     q_push;
   qent_type q_entry;
   logic     q_pop;
   logic     q_head_valid;
   qent_type q_head;

   // Register port.
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_sel = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_step_ff   <= CARRIER_STEP_RESET;
         modulator_step_ff <= MODULATOR_STEP_RESET;
         mod_depth_ff      <= MOD_DEPTH_RESET;
         amplitude_ff      <= AMPLITUDE_RESET;
         decay_coef_ff     <= DECAY_COEF_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_CARRIER_STEP:   carrier_step_ff   <= pwdata;
            REG_MODULATOR_STEP: modulator_step_ff <= pwdata;
            REG_MOD_DEPTH:      mod_depth_ff      <= pwdata[DEPTH_W-1:0];
            REG_AMPLITUDE:      amplitude_ff      <= pwdata[AMP_W-1:0];
            REG_DECAY_COEF:     decay_coef_ff     <= pwdata;
            default: ;
         endcase
      end
   end

   // Read-back mux.
   always_comb begin
      unique case (reg_sel)
         REG_CARRIER_STEP:   prdata = carrier_step_ff;
         REG_MODULATOR_STEP: prdata = modulator_step_ff;
         REG_MOD_DEPTH:      prdata = 32'(mod_depth_ff);
         REG_AMPLITUDE:      prdata = 32'(amplitude_ff);
         REG_DECAY_COEF:     prdata = decay_coef_ff;
         default:            prdata = '0;
      endcase
   end

   // Front: accept and classify.
   fbt_front #(.INDEX_BITS(INDEX_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_index (req_sample_index),
      .carrier_step     (carrier_step_ff),
      .modulator_step   (modulator_step_ff),
      .decay_coef       (decay_coef_ff),
      .queue_full       (q_full),
      .push             (q_push),
      .entry            (q_entry)
   );

   // Queue between front and back.
   fbt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   // Back: sample pipeline and output register.
   fbt_back #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (q_head_valid),
      .head             (q_head),
      .pop              (q_pop),
      .mod_depth        (mod_depth_ff),
      .amplitude        (amplitude_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_value (rsp_sample_value)
   );

endmodule

[rtl/fbt_sine_rom.sv]
// ----------------------------------------------------------------------------
// fbt_sine_rom
// Sine table with phase rounding to the nearest entry and a registered read.
// ----------------------------------------------------------------------------
module fbt_sine_rom #(
   parameter int unsigned TABLE_BITS = 10
) (
   input  logic               clock,
   input  logic               en,
   input  logic [31:0]        phase,
   output logic signed [15:0] value_ff
);
   import fbt_pkg::*;

   localparam int unsigned TABLE_SIZE = 1 << TABLE_BITS;

   logic signed [15:0]    rom [TABLE_SIZE];
   logic [TABLE_BITS-1:0] addr;

   // Constant table contents.
   for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_rom
      localparam logic signed [15:0] ENTRY = sine_entry(k, TABLE_BITS);
      assign rom[k] = ENTRY;
   end

   // Round the phase to the nearest entry; the index wraps around the turn.
   assign addr = phase[31 -: TABLE_BITS]
               + {{(TABLE_BITS-1){1'b0}}, phase[31-TABLE_BITS]};

   // Registered read.
   always_ff @(posedge clock) begin
      if (en) begin
         value_ff <= rom[addr];
      end
   end

endmodule

[rtl/fbt_exp_step.sv]
// ----------------------------------------------------------------------------
// fbt_exp_step
// One Horner step of exp(-y): p = 1 - ((y*p) >> 30) / K, in three stages.
// ----------------------------------------------------------------------------
module fbt_exp_step #(
   parameter int unsigned K = 1
) (
   input  logic              clock,
   input  logic              en,
   input  fbt_pkg::hterm_type term_in,
   output fbt_pkg::hterm_type term_out
);
   import fbt_pkg::*;

   // Reciprocal of K; one correction step makes the quotient exact.
   localparam logic [33:0] RECIP = 34'((64'd1 << 33) / K);
   localparam logic [3:0]  K_W   = 4'(K);

   hterm_type   a_term_ff;
   logic [60:0] a_prod_ff;
   hterm_type   b_term_ff;
   logic [29:0] b_t_ff;
   logic [29:0] b_q0_ff;
   hterm_type   c_term_ff;

   logic [29:0] a_t;
   logic [63:0] b_prod;
   logic [33:0] c_qk;
   logic [29:0] c_rem;
   logic [29:0] c_q;
   hterm_type   c_term_in;

   // Stage A: y times p.
   always_ff @(posedge clock) begin
      if (en) begin
         a_term_ff <= term_in;
         a_prod_ff <= 61'(term_in.y) * 61'(term_in.p);
      end
   end

   // Stage B: estimated quotient, low by at most one.
   assign a_t    = a_prod_ff[59:30];
   assign b_prod = 64'(a_t) * 64'(RECIP);

   always_ff @(posedge clock) begin
      if (en) begin
         b_term_ff <= a_term_ff;
         b_t_ff    <= a_t;
         b_q0_ff   <= b_prod[62:33];
      end
   end

   // Stage C: correct the quotient and form the next series value.
   assign c_qk  = 34'(b_q0_ff) * 34'(K_W);
   assign c_rem = b_t_ff - c_qk[29:0];
   assign c_q   = (c_rem >= 30'(K_W)) ? b_q0_ff + 30'd1 : b_q0_ff;

   always_comb begin
      c_term_in   = b_term_ff;
      c_term_in.p = Q30_ONE - 31'(c_q);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_term_ff <= c_term_in;
      end
   end

   assign term_out = c_term_ff;

endmodule

[rtl/fbt_front.sv]
// ----------------------------------------------------------------------------
// fbt_front
// Accepts sample indexes, forms both phases and splits the envelope exponent.
// ----------------------------------------------------------------------------
module fbt_front #(
   parameter int unsigned INDEX_BITS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [INDEX_BITS-1:0] req_sample_index,
   input  logic [31:0]           carrier_step,
   input  logic [31:0]           modulator_step,
   input  logic [31:0]           decay_coef,
   input  logic                  queue_full,
   output logic                  push,
   output fbt_pkg::qent_type     entry
);
   import fbt_pkg::*;

   localparam int unsigned PW = INDEX_BITS + 32;
   localparam logic [INDEX_BITS-1:0] SILENT_EXP = INDEX_BITS'(31);

   logic [PW-1:0]         pc_prod;
   logic [PW-1:0]         pm_prod;
   logic [PW-1:0]         e_prod;
   logic [INDEX_BITS-1:0] e_int;
   logic                  accept;
   qent_type              ent_in;
   qent_type              ent_ff;
   logic                  valid_ff;

   // Phase and envelope exponent products.
   assign pc_prod = PW'(req_sample_index) * PW'(carrier_step);
   assign pm_prod = PW'(req_sample_index) * PW'(modulator_step);
   assign e_prod  = PW'(req_sample_index) * PW'(decay_coef);
   assign e_int   = e_prod[PW-1:32];

   // Classify: the integer part of the exponent either shifts or silences.
   always_comb begin
      ent_in.carrier_phase = pc_prod[31:0];
      ent_in.mod_phase     = pm_prod[31:0];
      ent_in.decay_frac    = e_prod[31:0];
      ent_in.decay_shift   = e_int[4:0];
      ent_in.silent        = (e_int >= SILENT_EXP);
   end

   // A held beat blocks new input only while the queue is full.
   assign req_stall = valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = valid_ff && !queue_full;
   assign entry     = ent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (push) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ent_ff <= ent_in;
      end
   end

endmodule

[rtl/fbt_queue.sv]
// ----------------------------------------------------------------------------
// fbt_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module fbt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fbt_pkg::qent_type push_entry,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output fbt_pkg::qent_type head
);
   import fbt_pkg::*;

   qent_type                  mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_BITS:0]   count_ff;

   assign full       = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/fbt_back.sv]
// ----------------------------------------------------------------------------
// fbt_back
// Sample pipeline: two sine lookups, the exp() series, scaling and rounding.
// ----------------------------------------------------------------------------
module fbt_back #(
   parameter int unsigned SINE_TABLE_BITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  fbt_pkg::qent_type               head,
   output logic                            pop,
   input  logic [fbt_pkg::DEPTH_W-1:0]     mod_depth,
   input  logic [fbt_pkg::AMP_W-1:0]       amplitude,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [fbt_pkg::SAMPLE_W-1:0] rsp_sample_value
);
   import fbt_pkg::*;

   localparam int unsigned LAT = 3 + 3 * EXP_TERMS + 3;

   logic [LAT-1:0] valid_ff;
   logic           adv;

   logic [31:0] s1_pc_ff;
   logic [4:0]  s1_shift_ff;
   logic        s1_silent_ff;
   logic [29:0] s1_y_ff;
   logic signed [15:0] s1_ms;
   logic [63:0] y_prod;

   logic [31:0] s2_pc_ff;
   logic [31:0] s2_offs_ff;
   logic [4:0]  s2_shift_ff;
   logic        s2_silent_ff;
   logic [29:0] s2_y_ff;
   logic signed [16:0] depth_s;
   logic signed [16:0] ms_s;
   logic signed [33:0] offs_prod;

   logic [4:0]  s3_shift_ff;
   logic        s3_silent_ff;
   logic [29:0] s3_y_ff;
   logic signed [15:0] s3_sine;

   hterm_type chain [EXP_TERMS+1];

   logic [15:0] sine_neg;
   logic [14:0] sine_abs;
   logic [29:0] e1_am_ff;
   logic [30:0] e1_env_ff;
   logic        e1_neg_ff;
   logic [60:0] e2_mag_ff;
   logic        e2_neg_ff;

   logic [15:0]        e3_q;
   logic [44:0]        e3_rem;
   logic               e3_up;
   logic [16:0]        e3_qr;
   logic [16:0]        e3_qc;
   logic signed [17:0] e3_res;
   logic signed [15:0] e3_value;
   logic signed [15:0] value_ff;

   // The whole pipeline moves unless the output beat is held.
   assign adv       = !(valid_ff[LAT-1] && rsp_stall);
   assign pop       = adv && head_valid;
   assign rsp_valid = valid_ff[LAT-1];
   assign rsp_sample_value = value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[LAT-2:0], pop};
      end
   end

   // Stage 1: modulator sine lookup and series argument y = f * ln2.
   fbt_sine_rom #(.TABLE_BITS(SINE_TABLE_BITS)) u_mod_rom (
      .clock    (clock),
      .en       (adv),
      .phase    (head.mod_phase),
      .value_ff (s1_ms)
   );

   assign y_prod = 64'(head.decay_frac) * 64'(LN2_Q32);

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pc_ff     <= head.carrier_phase;
         s1_shift_ff  <= head.decay_shift;
         s1_silent_ff <= head.silent;
         s1_y_ff      <= y_prod[63:34];
      end
   end

   // Stage 2: modulation offset in Q0.32 turns.
   assign depth_s   = $signed({1'b0, mod_depth});
   assign ms_s      = {s1_ms[15], s1_ms};
   assign offs_prod = 34'(depth_s) * 34'(ms_s);

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_pc_ff     <= s1_pc_ff;
         s2_offs_ff   <= {offs_prod[28:0], 3'b000};
         s2_shift_ff  <= s1_shift_ff;
         s2_silent_ff <= s1_silent_ff;
         s2_y_ff      <= s1_y_ff;
      end
   end

   // Stage 3: carrier sine lookup at the modulated phase.
   fbt_sine_rom #(.TABLE_BITS(SINE_TABLE_BITS)) u_car_rom (
      .clock    (clock),
      .en       (adv),
      .phase    (s2_pc_ff + s2_offs_ff),
      .value_ff (s3_sine)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_shift_ff  <= s2_shift_ff;
         s3_silent_ff <= s2_silent_ff;
         s3_y_ff      <= s2_y_ff;
      end
   end

   // Series for 2^-f = exp(-y), from the highest term down to the first.
   always_comb begin
      chain[0].sine        = s3_sine;
      chain[0].decay_shift = s3_shift_ff;
      chain[0].silent      = s3_silent_ff;
      chain[0].y           = s3_y_ff;
      chain[0].p           = Q30_ONE;
   end

   for (genvar j = 0; j < EXP_TERMS; j++) begin : g_exp
      fbt_exp_step #(.K(EXP_TERMS - j)) u_step (
         .clock    (clock),
         .en       (adv),
         .term_in  (chain[j]),
         .term_out (chain[j+1])
      );
   end

   // Envelope shift and amplitude times sine magnitude.
   assign sine_neg = -chain[EXP_TERMS].sine;
   assign sine_abs = chain[EXP_TERMS].sine[15] ? sine_neg[14:0]
                                               : chain[EXP_TERMS].sine[14:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_am_ff  <= 30'(amplitude) * 30'(sine_abs);
         e1_env_ff <= chain[EXP_TERMS].silent ? '0
                    : (chain[EXP_TERMS].p >> chain[EXP_TERMS].decay_shift);
         e1_neg_ff <= chain[EXP_TERMS].sine[15];
      end
   end

   // Full magnitude product.
   always_ff @(posedge clock) begin
      if (adv) begin
         e2_mag_ff <= 61'(e1_am_ff) * 61'(e1_env_ff);
         e2_neg_ff <= e1_neg_ff;
      end
   end

   // Round half to even at 2^45, apply sign, saturate.
   always_comb begin
      e3_q   = e2_mag_ff[60:45];
      e3_rem = e2_mag_ff[44:0];
      e3_up  = (e3_rem > {1'b1, 44'd0}) || ((e3_rem == {1'b1, 44'd0}) && e3_q[0]);
      e3_qr  = {1'b0, e3_q} + {16'd0, e3_up};
      e3_qc  = (e3_qr > 17'd32768) ? 17'd32768 : e3_qr;
      e3_res = e2_neg_ff ? -$signed({1'b0, e3_qc}) : $signed({1'b0, e3_qc});
      if (e3_res > 18'sd32767) begin
         e3_value = 16'sd32767;
      end else if (e3_res < -18'sd32768) begin
         e3_value = -16'sd32768;
      end else begin
         e3_value = e3_res[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         value_ff <= e3_value;
      end
   end

endmodule

[rtl/fbt_checker.sv]
// ----------------------------------------------------------------------------
// fbt_checker
// Port-level checks of the FM bell tone block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_sample_value,
   input logic        pready
);

   // A held result beat stays up and keeps its value.
   `FBT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result beat dropped while stalled")
   `FBT_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_sample_value), "stalled result changed")

   // Reset leaves the pipeline empty and the input open.
   `FBT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall, "pipeline not empty after reset")

   // The register port never waits.
   `FBT_ASSERT_ALWAYS(a_pready, clock, pready, "register port not ready")

endmodule

bind fm_bell_tone_sample fbt_checker u_checker (.*);

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for the FM bell tone sample block. A scoreboard predicts every
// sample from the index and the current registers in integer arithmetic and
// checks each beat from the result channel in order.
// ----------------------------------------------------------------------------

// Prediction and checking of bell tone samples.
class bell_scoreboard;
   logic [31:0] carrier_step;
   logic [31:0] modulator_step;
   logic [15:0] mod_depth;
   logic [14:0] amplitude;
   logic [31:0] decay_coef;
   logic signed [15:0] pending_samples[$];
   int unsigned mismatches;
   int unsigned checked;

   function void set_defaults();
      carrier_step   = fbt_pkg::CARRIER_STEP_RESET;
      modulator_step = fbt_pkg::MODULATOR_STEP_RESET;
      mod_depth      = fbt_pkg::MOD_DEPTH_RESET;
      amplitude      = fbt_pkg::AMPLITUDE_RESET;
      decay_coef     = fbt_pkg::DECAY_COEF_RESET;
   endfunction

   // Sine of a Q0.32 phase from a 1024 entry quarter-wave table.
   function logic signed [15:0] table_sine(logic [31:0] phase);
      logic [32:0] idx;
      logic [9:0]  k;
      logic [1:0]  quad;
      logic [63:0] r, x, x2, p, s;
      logic signed [15:0] v;
      idx  = {1'b0, phase} + 33'd2097152;
      k    = idx[31:22];
      quad = k[9:8];
      r    = 64'(k[7:0]);
      if (quad[0]) begin
         r = 64'd256 - r;
      end
      x  = r << 22;
      x2 = (x * x) >> 30;
      p  = 64'd3864;
      p  = 64'd172272 - ((p * x2) >> 30);
      p  = 64'd5026995 - ((p * x2) >> 30);
      p  = 64'd85569306 - ((p * x2) >> 30);
      p  = 64'd693598668 - ((p * x2) >> 30);
      p  = 64'd1686629713 - ((p * x2) >> 30);
      s  = (p * x) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      v = 16'(s);
      return quad[1] ? -v : v;
   endfunction

   // Expected sample for one index.
   function logic signed [15:0] bell_sample(logic [19:0] n);
      logic [31:0] pc, pm, offs, ph;
      logic signed [15:0] ms, s;
      logic signed [63:0] prod;
      logic [63:0] e, y, env, mag, q, rem;
      logic [31:0] ip;
      int k;
      pc   = 32'(64'(n) * carrier_step);
      pm   = 32'(64'(n) * modulator_step);
      ms   = table_sine(pm);
      prod = $signed({48'd0, mod_depth}) * 64'(ms);
      offs = 32'(prod << 3);
      ph   = pc + offs;
      s    = table_sine(ph);
      e    = 64'(n) * 64'(decay_coef);
      ip   = e[63:32];
      y    = (64'(e[31:0]) * 64'd2977044472) >> 34;
      env  = 64'd1073741824;
      for (k = 11; k >= 1; k--) begin
         env = 64'd1073741824 - ((y * env) >> 30) / 64'(k);
      end
      env = (ip >= 31) ? 64'd0 : (env >> ip);
      mag = 64'(amplitude) * 64'(s < 0 ? -s : s) * env;
      q   = mag >> 45;
      rem = mag & ((64'd1 << 45) - 1);
      if (rem > (64'd1 << 44) || (rem == (64'd1 << 44) && q[0])) begin
         q++;
      end
      if (s < 0) begin
         return (q >= 32768) ? -16'sd32768 : -$signed(16'(q));
      end
      return (q > 32767) ? 16'sd32767 : 16'(q);
   endfunction

   function void note_index(logic [19:0] n);
      pending_samples.push_back(bell_sample(n));
   endfunction

   function void report(string what);
      $display("MISMATCH: %s", what);
      mismatches++;
   endfunction

   function void check_sample(logic signed [15:0] got);
      logic signed [15:0] want;
      checked++;
      if (pending_samples.size() == 0) begin
         report($sformatf("unexpected sample %0d", got));
         return;
      end
      want = pending_samples.pop_front();
      if (got !== want) begin
         report($sformatf("sample_value got %0d expected %0d", got, want));
      end
   endfunction
endclass

module tb;
   localparam int WATCHDOG_LIMIT = 20000;

   // Register addresses.
   localparam logic [4:0] ADDR_CARRIER_STEP   = 5'd0;
   localparam logic [4:0] ADDR_MODULATOR_STEP = 5'd4;
   localparam logic [4:0] ADDR_MOD_DEPTH      = 5'd8;
   localparam logic [4:0] ADDR_AMPLITUDE      = 5'd12;
   localparam logic [4:0] ADDR_DECAY_COEF     = 5'd16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [19:0] req_sample_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic signed [15:0] rsp_sample_value;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   bell_scoreboard board = new();
   int unsigned idle_cycles;
   int unsigned items_sent;
   int unsigned stall_mode;

   fm_bell_tone_sample uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample_index(req_sample_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sample_value(rsp_sample_value),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Check result beats and watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            board.check_sample(rsp_sample_value);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("Testbench completed WITH ERRORS");
               $finish;
            end
         end
      end
   end

   // Receiver stalls on a pattern that changes between phases.
   always @(posedge clock) begin
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   task automatic write_reg(input logic [4:0] addr, input logic [31:0] value);
      psel   <= 1'b1;
      pwrite <= 1'b1;
      paddr  <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (addr)
         ADDR_CARRIER_STEP:   board.carrier_step   = value;
         ADDR_MODULATOR_STEP: board.modulator_step = value;
         ADDR_MOD_DEPTH:      board.mod_depth      = value[15:0];
         ADDR_AMPLITUDE:      board.amplitude      = value[14:0];
         ADDR_DECAY_COEF:     board.decay_coef     = value;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [31:0] cs, input logic [31:0] ms,
                            input logic [31:0] md, input logic [31:0] amp,
                            input logic [31:0] dc);
      write_reg(ADDR_CARRIER_STEP, cs);
      write_reg(ADDR_MODULATOR_STEP, ms);
      write_reg(ADDR_MOD_DEPTH, md);
      write_reg(ADDR_AMPLITUDE, amp);
      write_reg(ADDR_DECAY_COEF, dc);
   endtask

   // Send one index and hold it until it is taken.
   task automatic send_index(input logic [19:0] n);
      req_valid        <= 1'b1;
      req_sample_index <= n;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_index(n);
      items_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Let every expected sample arrive, then let the pipeline drain.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_samples.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // Random indices in bursts, mostly small with some anywhere in range.
   task automatic random_phase(input int count);
      int left;
      int burst;
      logic [19:0] n;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && left > 0) begin
            case ($urandom_range(0, 3))
               0: n = 20'($urandom);
               1: n = 20'($urandom_range(0, 1000));
               default: n = 20'($urandom_range(0, 200000));
            endcase
            send_index(n);
            burst--;
            left--;
         end
         if ($urandom_range(0, 2) != 0) begin
            pause_sender($urandom_range(1, 8));
         end
      end
   endtask

   initial begin
      logic [19:0] directed[$];
      int p;
      board.set_defaults();
      idle_cycles = 0;
      items_sent  = 0;
      stall_mode  = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed indices with the reset settings, from zero up to the largest index.
      directed = '{20'd0, 20'd1, 20'd2, 20'd100, 20'd157, 20'd44100, 20'd90000,
                   20'd524288, 20'hAAAAA, 20'h55555, 20'hFFFFE, 20'hFFFFF};
      foreach (directed[i]) send_index(directed[i]);
      drain();

      // Extreme register values, both ends.
      write_all(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0000FFFF, 32'h00007FFF, 32'd0);
      foreach (directed[i]) send_index(directed[i]);
      drain();
      write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFFFFFF);
      send_index(20'd0);
      send_index(20'd1);
      send_index(20'hFFFFF);
      drain();

      // Random phases, each with a fresh register setting and stall pattern.
      for (p = 0; p < 6; p++) begin
         stall_mode = p % 3;
         if (p == 0) begin
            write_all(fbt_pkg::CARRIER_STEP_RESET, fbt_pkg::MODULATOR_STEP_RESET,
                      fbt_pkg::MOD_DEPTH_RESET, fbt_pkg::AMPLITUDE_RESET,
                      fbt_pkg::DECAY_COEF_RESET);
         end else begin
            write_all($urandom, $urandom, $urandom_range(0, 65535),
                      $urandom_range(0, 32767),
                      ($urandom_range(0, 1) == 0) ? $urandom_range(0, 200000) : $urandom);
         end
         random_phase(100);
         drain();
      end

      $display("Covered %0d indices over eight register settings; %0d samples checked.",
               items_sent, board.checked);
      if (board.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

[fm_bell_tone_sample.f]
+incdir+rtl
rtl/fbt_pkg.sv
rtl/fbt_sine_rom.sv
rtl/fbt_exp_step.sv
rtl/fbt_front.sv
rtl/fbt_queue.sv
rtl/fbt_back.sv
rtl/fm_bell_tone_sample.sv
rtl/fbt_checker.sv
test/tb.sv
